/* src/dipolar_ising_config_energy_core_assert.svh */
// ----------------------------------------------------------------------------
// Dipolar Ising energy core assertion macros
// Shared property forms for the checks in the core's RTL.
// ----------------------------------------------------------------------------
`ifndef DIPOLAR_ISING_CONFIG_ENERGY_CORE_ASSERT_SVH
`define DIPOLAR_ISING_CONFIG_ENERGY_CORE_ASSERT_SVH

// Same-cycle implication under the asynchronous active-low reset.
`define DICE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("dice assertion failed");

// Next-cycle implication under the asynchronous active-low reset.
`define DICE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("dice assertion failed");

`endif

/* src/dice_pkg.sv */
// ----------------------------------------------------------------------------
// Dipolar Ising energy package
// Types, codes and fixed constants shared by the core's modules.
// ----------------------------------------------------------------------------
package dice_pkg;

	localparam int IDX_W = 5;
	localparam int SC_W = 5;
	localparam int RAD_W = 16;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam int DVD_W = 60;
	localparam int DVS_W = 51;
	localparam int ENERGY_W = 48;
	localparam int MAG_W = 32;
	localparam logic [SC_W-1:0] SPIN_COUNT_RST = 5'd16;
	localparam logic [RAD_W-1:0] RADIUS_RST = 16'd256;
	localparam logic signed [19:0] HALF_SQRT2_Q16 = 20'sd46341;

	typedef enum logic [0:0] {
		REG_SPIN_COUNT = 1'b0,
		REG_RADIUS     = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		DM_SQRT,
		DM_SHORT,
		DM_LONG
	} div_mode_t;

	typedef enum logic [5:0] {
		OP_NONE, OP_LOAD, OP_INIT, OP_LIM, OP_LDI, OP_MAGM, OP_MAGA, OP_LDJ,
		OP_DXX, OP_DYY, OP_D2, OP_COIN, OP_SQS, OP_R, OP_UXS, OP_UX, OP_UYS,
		OP_UY, OP_PIM1, OP_PIM2, OP_PI, OP_PJM1, OP_PJM2, OP_PJ, OP_AM1,
		OP_AM2, OP_AM3, OP_A, OP_R2, OP_R3, OP_TS, OP_T, OP_OUT
	} op_t;

	typedef enum logic [5:0] {
		ST_IDLE, ST_LIM, ST_RDI, ST_LDI, ST_MAGM, ST_MAGA, ST_JCHK, ST_RDJ,
		ST_LDJ, ST_DXX, ST_DYY, ST_D2, ST_CHK, ST_SQS, ST_SQW, ST_UXS, ST_UXW,
		ST_UYS, ST_UYW, ST_PIM1, ST_PIM2, ST_PI, ST_PJM1, ST_PJM2, ST_PJ,
		ST_AM1, ST_AM2, ST_AM3, ST_A, ST_R2, ST_R3, ST_TS, ST_TW, ST_NEXTJ,
		ST_NEXTI, ST_DONE
	} state_t;

	typedef struct packed {
		op_t op;
		logic [IDX_W-1:0] addr;
	} dice_cmd_t;

	typedef struct packed {
		logic d2_zero;
		logic d2_over;
		logic div_busy;
	} dice_status_t;

endpackage

/* src/dice_if.sv */
// ----------------------------------------------------------------------------
// Dipolar Ising energy channels
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface dice_in_if;
	logic valid;
	logic ready;
	logic func;
	logic [3:0] spin_index;
	logic signed [15:0] pos_x;
	logic signed [15:0] pos_y;
	logic signed [15:0] moment_x;
	logic signed [15:0] moment_y;
	logic [15:0] config_index;

	modport source (output valid, func, spin_index, pos_x, pos_y, moment_x, moment_y,
		config_index, input ready);
	modport sink (input valid, func, spin_index, pos_x, pos_y, moment_x, moment_y,
		config_index, output ready);
endinterface

interface dice_out_if;
	logic valid;
	logic ready;
	logic signed [47:0] energy;
	logic signed [31:0] magnetization;
	logic [15:0] config_echo;
	logic coincident_pair;

	modport source (output valid, energy, magnetization, config_echo, coincident_pair,
		input ready);
	modport sink (input valid, energy, magnetization, config_echo, coincident_pair,
		output ready);
endinterface

/* src/dipolar_ising_config_energy_core.sv */
// ----------------------------------------------------------------------------
// Dipolar Ising configuration energy core
// Top level: register port, controller and datapath for pair energy sums.
// ----------------------------------------------------------------------------
// A load beat writes one spin. A compute beat walks all pairs of the first
// spin_count spins, at most MAX_SPINS, and returns one result beat. A pair
// outside the radius or at zero distance adds no energy term; each pair
// inside it goes through the shared divide and root unit, which settles one
// quotient bit per cycle (17 bits for the root, 32 for each direction
// component, 60 for the pair term).
// One beat is worked on at a time; a finished result waits in its output
// register while the next beat is taken.
module dipolar_ising_config_energy_core #(
	parameter int MAX_SPINS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [dice_pkg::PADDR_W-1:0] paddr,
	input  logic [dice_pkg::PDATA_W-1:0] pwdata,
	output logic [dice_pkg::PDATA_W-1:0] prdata,
	output logic pready,
	dice_in_if.sink in_ch,
	dice_out_if.source out_ch
);
	import dice_pkg::*;

	logic [SC_W-1:0] spin_count;
	logic [RAD_W-1:0] interaction_radius;
	dice_cmd_t cmd;
	dice_status_t status;

	dice_regs u_regs (
		.clk                (clk),
		.arst_n             (arst_n),
		.psel               (psel),
		.penable            (penable),
		.pwrite             (pwrite),
		.paddr              (paddr),
		.pwdata             (pwdata),
		.prdata             (prdata),
		.pready             (pready),
		.spin_count         (spin_count),
		.interaction_radius (interaction_radius)
	);

	dice_ctrl #(.MAX_SPINS(MAX_SPINS)) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_ch.valid),
		.in_func    (in_ch.func),
		.in_ready   (in_ch.ready),
		.out_valid  (out_ch.valid),
		.out_ready  (out_ch.ready),
		.spin_count (spin_count),
		.cmd        (cmd),
		.status     (status)
	);

	dice_datapath #(.MAX_SPINS(MAX_SPINS)) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.status             (status),
		.interaction_radius (interaction_radius),
		.spin_index         (in_ch.spin_index),
		.pos_x              (in_ch.pos_x),
		.pos_y              (in_ch.pos_y),
		.moment_x           (in_ch.moment_x),
		.moment_y           (in_ch.moment_y),
		.config_index       (in_ch.config_index),
		.energy             (out_ch.energy),
		.magnetization      (out_ch.magnetization),
		.config_echo        (out_ch.config_echo),
		.coincident_pair    (out_ch.coincident_pair)
	);
endmodule

/* src/dice_regs.sv */
// ----------------------------------------------------------------------------
// Dipolar Ising energy configuration registers
// APB-style register file for spin count and interaction radius.
// ----------------------------------------------------------------------------
module dice_regs (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [dice_pkg::PADDR_W-1:0] paddr,
	input  logic [dice_pkg::PDATA_W-1:0] pwdata,
	output logic [dice_pkg::PDATA_W-1:0] prdata,
	output logic pready,
	output logic [dice_pkg::SC_W-1:0] spin_count,
	output logic [dice_pkg::RAD_W-1:0] interaction_radius
);
	import dice_pkg::*;

	reg_idx_t idx;
	logic wr_en;

	assign idx = reg_idx_t'(paddr[2]);
	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spin_count <= SPIN_COUNT_RST;
			interaction_radius <= RADIUS_RST;
		end else if (wr_en) begin
			case (idx)
				REG_SPIN_COUNT: spin_count <= pwdata[SC_W-1:0];
				REG_RADIUS:     interaction_radius <= pwdata[RAD_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_SPIN_COUNT: prdata = PDATA_W'(spin_count);
			REG_RADIUS:     prdata = PDATA_W'(interaction_radius);
			default:        prdata = '0;
		endcase
	end
endmodule

/* src/dice_div.sv */
// ----------------------------------------------------------------------------
// Dipolar Ising energy divide and root unit
// Restoring divider and integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module dice_div (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  dice_pkg::div_mode_t mode,
	input  logic [dice_pkg::DVD_W-1:0] dividend,
	input  logic [dice_pkg::DVS_W-1:0] divisor,
	output logic busy,
	output logic [dice_pkg::DVD_W-1:0] quot
);
	import dice_pkg::*;

	logic busy_q;
	logic [5:0] cnt_q;
	div_mode_t mode_q;
	logic [DVD_W-1:0] sh_q;
	logic [DVS_W:0] rem_q;
	logic [DVD_W-1:0] quot_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W:0] rem_div;
	logic [19:0] rem_rt;
	logic [19:0] trial;
	logic ge_div;
	logic ge_rt;

	assign rem_div = {rem_q[DVS_W-1:0], sh_q[DVD_W-1]};
	assign ge_div = rem_div >= {1'b0, dvs_q};
	assign rem_rt = {rem_q[17:0], sh_q[DVD_W-1:DVD_W-2]};
	assign trial = {1'b0, quot_q[16:0], 2'b01};
	assign ge_rt = rem_rt >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			case (mode)
				DM_SQRT:  cnt_q <= 6'd17;
				DM_SHORT: cnt_q <= 6'd32;
				default:  cnt_q <= 6'd60;
			endcase
		end else if (busy_q) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd1) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mode_q <= mode;
			dvs_q <= divisor;
			rem_q <= '0;
			quot_q <= '0;
			case (mode)
				DM_SQRT:  sh_q <= {dividend[33:0], 26'b0};
				DM_SHORT: sh_q <= {dividend[31:0], 28'b0};
				default:  sh_q <= dividend;
			endcase
		end else if (busy_q) begin
			if (mode_q == DM_SQRT) begin
				rem_q <= (DVS_W+1)'(ge_rt ? rem_rt - trial : rem_rt);
				quot_q <= {quot_q[DVD_W-2:0], ge_rt};
				sh_q <= {sh_q[DVD_W-3:0], 2'b00};
			end else begin
				rem_q <= ge_div ? rem_div - {1'b0, dvs_q} : rem_div;
				quot_q <= {quot_q[DVD_W-2:0], ge_div};
				sh_q <= {sh_q[DVD_W-2:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign quot = quot_q;
endmodule

/* src/dice_datapath.sv */
// ----------------------------------------------------------------------------
// Dipolar Ising energy datapath
// Spin store, shared multiplier, divide unit and the pair accumulators.
// ----------------------------------------------------------------------------
module dice_datapath #(
	parameter int MAX_SPINS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  dice_pkg::dice_cmd_t cmd,
	output dice_pkg::dice_status_t status,
	input  logic [dice_pkg::RAD_W-1:0] interaction_radius,
	input  logic [3:0] spin_index,
	input  logic signed [15:0] pos_x,
	input  logic signed [15:0] pos_y,
	input  logic signed [15:0] moment_x,
	input  logic signed [15:0] moment_y,
	input  logic [15:0] config_index,
	output logic signed [47:0] energy,
	output logic signed [31:0] magnetization,
	output logic [15:0] config_echo,
	output logic coincident_pair
);
	import dice_pkg::*;

	localparam int AW = $clog2(MAX_SPINS);
	localparam logic signed [60:0] E_MAX = 61'sd140737488355327;
	localparam logic signed [60:0] E_MIN = -61'sd140737488355328;

	logic [63:0] mem_q [MAX_SPINS];
	logic [63:0] rd_q;
	logic [IDX_W-1:0] widx;
	logic [15:0] pattern_q;
	logic flip;
	logic signed [16:0] ld_px, ld_py, ld_mx, ld_my;
	logic signed [16:0] pxi_q, pyi_q, mxi_q, myi_q, mxj_q, myj_q;
	logic signed [16:0] dx_q, dy_q, ux_q, uy_q;
	logic [16:0] adx, ady;
	logic [33:0] d2_q;
	logic [31:0] r2lim_q;
	logic [16:0] r_q;
	logic signed [35:0] mul_a;
	logic signed [19:0] mul_b;
	logic mul_en;
	logic signed [55:0] prod_q;
	logic signed [35:0] tmp_q;
	logic signed [35:0] dot;
	logic [35:0] adot;
	logic signed [19:0] pi_q, pj_q, pnew;
	logic signed [39:0] a_q;
	logic [39:0] abs_a;
	logic [35:0] pm;
	logic [19:0] rnd;
	logic signed [47:0] energy_q;
	logic signed [31:0] mag_q;
	logic coin_q;
	logic signed [60:0] term, esum;
	logic div_start;
	div_mode_t div_mode;
	logic [DVD_W-1:0] div_dvd;
	logic [DVS_W-1:0] div_dvs;
	logic div_busy;
	logic [DVD_W-1:0] div_quot;
	logic signed [16:0] qsh;

	assign widx = IDX_W'(spin_index);
	assign flip = !cmd.addr[4] && pattern_q[cmd.addr[3:0]];
	assign ld_px = 17'(signed'(rd_q[63:48]));
	assign ld_py = 17'(signed'(rd_q[47:32]));
	assign ld_mx = flip ? -17'(signed'(rd_q[31:16])) : 17'(signed'(rd_q[31:16]));
	assign ld_my = flip ? -17'(signed'(rd_q[15:0])) : 17'(signed'(rd_q[15:0]));
	assign adx = dx_q[16] ? 17'(-dx_q) : 17'(dx_q);
	assign ady = dy_q[16] ? 17'(-dy_q) : 17'(dy_q);
	assign dot = tmp_q + prod_q[35:0];
	assign adot = dot[35] ? 36'(-dot) : 36'(dot);
	assign pnew = dot[35] ? -20'(signed'({1'b0, adot[34:14]})) : 20'(signed'({1'b0, adot[34:14]}));
	assign abs_a = a_q[39] ? 40'(-a_q) : 40'(a_q);
	assign pm = prod_q[35] ? 36'(-prod_q[35:0]) : 36'(prod_q[35:0]);
	assign rnd = 20'((pm + 36'd32768) >> 16);
	assign qsh = 17'(signed'({1'b0, div_quot[15:0]}));
	assign term = a_q[39] ? -61'(signed'({1'b0, div_quot})) : 61'(signed'({1'b0, div_quot}));
	assign esum = 61'(energy_q) + term;

	always_ff @(posedge clk) begin
		if (cmd.op == OP_LOAD && widx < IDX_W'(MAX_SPINS)) begin
			mem_q[widx[AW-1:0]] <= {pos_x, pos_y, moment_x, moment_y};
		end
		rd_q <= mem_q[cmd.addr[AW-1:0]];
	end

	always_comb begin
		mul_en = 1'b1;
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_INIT: begin
				mul_a = 36'(signed'({1'b0, interaction_radius}));
				mul_b = 20'(signed'({1'b0, interaction_radius}));
			end
			OP_MAGM: begin
				mul_a = 36'(mxi_q) + 36'(myi_q);
				mul_b = HALF_SQRT2_Q16;
			end
			OP_DXX: begin
				mul_a = 36'(dx_q);
				mul_b = 20'(dx_q);
			end
			OP_DYY: begin
				mul_a = 36'(dy_q);
				mul_b = 20'(dy_q);
			end
			OP_PIM1: begin
				mul_a = 36'(mxi_q);
				mul_b = 20'(ux_q);
			end
			OP_PIM2: begin
				mul_a = 36'(myi_q);
				mul_b = 20'(uy_q);
			end
			OP_PJM1: begin
				mul_a = 36'(mxj_q);
				mul_b = 20'(ux_q);
			end
			OP_PJM2: begin
				mul_a = 36'(myj_q);
				mul_b = 20'(uy_q);
			end
			OP_AM1: begin
				mul_a = 36'(mxi_q);
				mul_b = 20'(mxj_q);
			end
			OP_AM2: begin
				mul_a = 36'(myi_q);
				mul_b = 20'(myj_q);
			end
			OP_AM3: begin
				mul_a = 36'(pi_q);
				mul_b = pj_q;
			end
			OP_R2: begin
				mul_a = 36'(signed'({1'b0, r_q}));
				mul_b = 20'(signed'({1'b0, r_q}));
			end
			OP_R3: begin
				mul_a = 36'(signed'({1'b0, prod_q[33:0]}));
				mul_b = 20'(signed'({1'b0, r_q}));
			end
			default: mul_en = 1'b0;
		endcase
	end

	always_comb begin
		div_start = 1'b1;
		div_mode = DM_LONG;
		div_dvd = '0;
		div_dvs = '0;
		case (cmd.op)
			OP_SQS: begin
				div_mode = DM_SQRT;
				div_dvd = DVD_W'(d2_q);
			end
			OP_UXS: begin
				div_mode = DM_SHORT;
				div_dvd = DVD_W'({adx, 14'b0});
				div_dvs = DVS_W'(r_q);
			end
			OP_UYS: begin
				div_mode = DM_SHORT;
				div_dvd = DVD_W'({ady, 14'b0});
				div_dvs = DVS_W'(r_q);
			end
			OP_TS: begin
				div_dvd = {abs_a, 20'b0};
				div_dvs = prod_q[DVS_W-1:0];
			end
			default: div_start = 1'b0;
		endcase
	end

	dice_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.mode     (div_mode),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.busy     (div_busy),
		.quot     (div_quot)
	);

	always_ff @(posedge clk) begin
		if (mul_en) begin
			prod_q <= mul_a * mul_b;
		end
		case (cmd.op)
			OP_INIT: begin
				pattern_q <= config_index;
				energy_q <= '0;
				mag_q <= '0;
				coin_q <= 1'b0;
			end
			OP_LIM: r2lim_q <= prod_q[31:0];
			OP_LDI: begin
				pxi_q <= ld_px;
				pyi_q <= ld_py;
				mxi_q <= ld_mx;
				myi_q <= ld_my;
			end
			OP_MAGA: mag_q <= prod_q[35] ? mag_q - MAG_W'(rnd) : mag_q + MAG_W'(rnd);
			OP_LDJ: begin
				mxj_q <= ld_mx;
				myj_q <= ld_my;
				dx_q <= pxi_q - ld_px;
				dy_q <= pyi_q - ld_py;
			end
			OP_DYY: d2_q <= prod_q[33:0];
			OP_D2:  d2_q <= d2_q + prod_q[33:0];
			OP_COIN: coin_q <= 1'b1;
			OP_R:   r_q <= div_quot[16:0];
			OP_UX:  ux_q <= dx_q[16] ? -qsh : qsh;
			OP_UY:  uy_q <= dy_q[16] ? -qsh : qsh;
			OP_PIM2, OP_PJM2, OP_AM2: tmp_q <= prod_q[35:0];
			OP_PI:  pi_q <= pnew;
			OP_PJ:  pj_q <= pnew;
			OP_AM3: tmp_q <= tmp_q + prod_q[35:0];
			OP_A:   a_q <= 40'(tmp_q) - 40'(prod_q) - (40'(prod_q) <<< 1);
			OP_T: begin
				if (esum > E_MAX) begin
					energy_q <= E_MAX[47:0];
				end else if (esum < E_MIN) begin
					energy_q <= E_MIN[47:0];
				end else begin
					energy_q <= esum[47:0];
				end
			end
			OP_OUT: begin
				energy <= energy_q;
				magnetization <= mag_q;
				config_echo <= pattern_q;
				coincident_pair <= coin_q;
			end
			default: ;
		endcase
	end

	assign status.d2_zero = d2_q == '0;
	assign status.d2_over = d2_q > {2'b00, r2lim_q};
	assign status.div_busy = div_busy;
endmodule

/* src/dice_ctrl.sv */
// ----------------------------------------------------------------------------
// Dipolar Ising energy controller
// Sequences spin loads, pair walks and result hand-off over the datapath.
// ----------------------------------------------------------------------------
module dice_ctrl #(
	parameter int MAX_SPINS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_func,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  logic [dice_pkg::SC_W-1:0] spin_count,
	output dice_pkg::dice_cmd_t cmd,
	input  dice_pkg::dice_status_t status
);
	import dice_pkg::*;

	localparam int CW = $clog2(MAX_SPINS + 1);

	state_t state_q, state_d;
	logic [CW-1:0] i_q, j_q, n_q;
	logic out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (in_valid && in_func) state_d = ST_LIM;
			ST_LIM:   state_d = (n_q == '0) ? ST_DONE : ST_RDI;
			ST_RDI:   state_d = ST_LDI;
			ST_LDI:   state_d = ST_MAGM;
			ST_MAGM:  state_d = ST_MAGA;
			ST_MAGA:  state_d = ST_JCHK;
			ST_JCHK:  state_d = (j_q < n_q) ? ST_RDJ : ST_NEXTI;
			ST_RDJ:   state_d = ST_LDJ;
			ST_LDJ:   state_d = ST_DXX;
			ST_DXX:   state_d = ST_DYY;
			ST_DYY:   state_d = ST_D2;
			ST_D2:    state_d = ST_CHK;
			ST_CHK: begin
				if (status.d2_over || status.d2_zero) begin
					state_d = ST_NEXTJ;
				end else begin
					state_d = ST_SQS;
				end
			end
			ST_SQS:   state_d = ST_SQW;
			ST_SQW:   if (!status.div_busy) state_d = ST_UXS;
			ST_UXS:   state_d = ST_UXW;
			ST_UXW:   if (!status.div_busy) state_d = ST_UYS;
			ST_UYS:   state_d = ST_UYW;
			ST_UYW:   if (!status.div_busy) state_d = ST_PIM1;
			ST_PIM1:  state_d = ST_PIM2;
			ST_PIM2:  state_d = ST_PI;
			ST_PI:    state_d = ST_PJM1;
			ST_PJM1:  state_d = ST_PJM2;
			ST_PJM2:  state_d = ST_PJ;
			ST_PJ:    state_d = ST_AM1;
			ST_AM1:   state_d = ST_AM2;
			ST_AM2:   state_d = ST_AM3;
			ST_AM3:   state_d = ST_A;
			ST_A:     state_d = ST_R2;
			ST_R2:    state_d = ST_R3;
			ST_R3:    state_d = ST_TS;
			ST_TS:    state_d = ST_TW;
			ST_TW:    if (!status.div_busy) state_d = ST_NEXTJ;
			ST_NEXTJ: state_d = ST_JCHK;
			ST_NEXTI: begin
				state_d = ((CW+1)'(i_q) + 1'b1 < (CW+1)'(n_q)) ? ST_RDI : ST_DONE;
			end
			ST_DONE:  if (!out_valid_q || out_ready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.op = OP_NONE;
		cmd.addr = IDX_W'(i_q);
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) cmd.op = in_func ? OP_INIT : OP_LOAD;
			end
			ST_LIM:  cmd.op = OP_LIM;
			ST_LDI:  cmd.op = OP_LDI;
			ST_MAGM: cmd.op = OP_MAGM;
			ST_MAGA: cmd.op = OP_MAGA;
			ST_RDJ:  cmd.addr = IDX_W'(j_q);
			ST_LDJ: begin
				cmd.addr = IDX_W'(j_q);
				cmd.op = OP_LDJ;
			end
			ST_DXX:  cmd.op = OP_DXX;
			ST_DYY:  cmd.op = OP_DYY;
			ST_D2:   cmd.op = OP_D2;
			ST_CHK:  if (!status.d2_over && status.d2_zero) cmd.op = OP_COIN;
			ST_SQS:  cmd.op = OP_SQS;
			ST_SQW:  if (!status.div_busy) cmd.op = OP_R;
			ST_UXS:  cmd.op = OP_UXS;
			ST_UXW:  if (!status.div_busy) cmd.op = OP_UX;
			ST_UYS:  cmd.op = OP_UYS;
			ST_UYW:  if (!status.div_busy) cmd.op = OP_UY;
			ST_PIM1: cmd.op = OP_PIM1;
			ST_PIM2: cmd.op = OP_PIM2;
			ST_PI:   cmd.op = OP_PI;
			ST_PJM1: cmd.op = OP_PJM1;
			ST_PJM2: cmd.op = OP_PJM2;
			ST_PJ:   cmd.op = OP_PJ;
			ST_AM1:  cmd.op = OP_AM1;
			ST_AM2:  cmd.op = OP_AM2;
			ST_AM3:  cmd.op = OP_AM3;
			ST_A:    cmd.op = OP_A;
			ST_R2:   cmd.op = OP_R2;
			ST_R3:   cmd.op = OP_R3;
			ST_TS:   cmd.op = OP_TS;
			ST_TW:   if (!status.div_busy) cmd.op = OP_T;
			ST_DONE: if (!out_valid_q || out_ready) cmd.op = OP_OUT;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q <= '0;
			j_q <= '0;
			n_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.op == OP_INIT) begin
				i_q <= '0;
				n_q <= (spin_count > SC_W'(MAX_SPINS)) ? CW'(MAX_SPINS) : CW'(spin_count);
			end
			if (state_q == ST_MAGA) j_q <= i_q + 1'b1;
			if (state_q == ST_NEXTJ) j_q <= j_q + 1'b1;
			if (state_q == ST_NEXTI) i_q <= i_q + 1'b1;
			if (cmd.op == OP_OUT) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	`include "dipolar_ising_config_energy_core_assert.svh"

	`DICE_ASSERT_IMPL(a_div_idle_start, clk, arst_n, (cmd.op == OP_SQS || cmd.op == OP_UXS || cmd.op == OP_UYS || cmd.op == OP_TS), !status.div_busy)
	`DICE_ASSERT_NEXT(a_out_raised, clk, arst_n, cmd.op == OP_OUT, out_valid_q)
	`DICE_ASSERT_IMPL(a_pair_order, clk, arst_n, state_q == ST_LDJ, (i_q < j_q) && (j_q < n_q))
endmodule
